### rtl/lcs_pkg.sv
// Shared constants, types and helpers for the life automaton step block.
`default_nettype none

package lcs_pkg;

   // Grid storage limits
   localparam int MAX_ROWS = 64;
   localparam int MAX_COLS = 64;
   localparam int MAX_DIM  = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;

   // Internal index and extent widths
   localparam int ROW_W      = $clog2(MAX_ROWS);
   localparam int COL_W      = $clog2(MAX_COLS);
   localparam int EXT_W      = $clog2(MAX_DIM + 1);
   localparam int ADDR_W     = ROW_W + 1;
   localparam int RAM_WORDS  = 2 ** ADDR_W;
   localparam int PAD_IDX_W  = $clog2(MAX_COLS + 2);

   // Fixed field widths of the channels
   localparam int FLD_ROW_W  = 6;
   localparam int FLD_COL_W  = 6;
   localparam int LIVE_W     = 13;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 7;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_IN_USE = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_IN_USE = 4'd1;

   // Extent reset value and rule thresholds
   localparam logic [CSR_DATA_W-1:0] EXTENT_RESET = 7'd64;
   localparam logic [3:0]            BIRTH_COUNT  = 4'd3;
   localparam logic [3:0]            SURVIVE_LOW  = 4'd2;

   // Controller states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RD_SELF,
      ST_RD_BELOW,
      ST_EMIT
   } lcs_state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic clear_wr;
      logic load_wr;
      logic adv_start;
      logic rd_self;
      logic rd_below;
      logic emit;
   } lcs_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic clear_last;
   } lcs_stat_type;

   // Zero counts as one, anything above the storage limit counts as the limit
   function automatic logic [EXT_W-1:0] clamp_extent(input logic [CSR_DATA_W-1:0] v,
                                                    input int maxv);
      logic [EXT_W-1:0] res;
      if (v == '0) begin
         res = EXT_W'(1);
      end else if (32'(v) > maxv) begin
         res = EXT_W'(maxv);
      end else begin
         res = EXT_W'(v);
      end
      return res;
   endfunction

endpackage

`default_nettype wire

### rtl/lcs_if.sv
// Channel interfaces: request, response and register write.
`default_nettype none

interface lcs_req_if;
   logic                        valid;
   logic                        ready;
   logic                        mode;
   logic                        cell_in;
   logic [lcs_pkg::FLD_ROW_W-1:0] load_row;
   logic [lcs_pkg::FLD_COL_W-1:0] load_col;

   modport source (output valid, mode, cell_in, load_row, load_col, input ready);
   modport sink   (input valid, mode, cell_in, load_row, load_col, output ready);
endinterface

interface lcs_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        cell_out;
   logic [lcs_pkg::FLD_ROW_W-1:0] row_out;
   logic [lcs_pkg::FLD_COL_W-1:0] col_out;
   logic [lcs_pkg::LIVE_W-1:0]    live_count;
   logic                        last;

   modport source (output valid, cell_out, row_out, col_out, live_count, last, input ready);
   modport sink   (input valid, cell_out, row_out, col_out, live_count, last, output ready);
endinterface

interface lcs_csr_if;
   logic                           valid;
   logic                           ready;
   logic [lcs_pkg::CSR_IDX_W-1:0]  index;
   logic [lcs_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/lcs_ram.sv
// Generic single-write, single-read RAM with bit write mask and registered read.
`default_nettype none

module lcs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wmask,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Masked write
   always_ff @(posedge clock) begin
      if (we) begin
         for (int i = 0; i < WIDTH; i++) begin
            if (wmask[i]) begin
               mem[waddr][i] <= wdata[i];
            end
         end
      end
   end

   // Registered read, holds when not enabled
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

### rtl/lcs_ctrl.sv
// Sequencing state machine: clearing pass, loads, row reads and result handoff.
`default_nettype none

module lcs_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_mode,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire lcs_pkg::lcs_stat_type stat,
   output lcs_pkg::lcs_cmd_type       cmd
);
   import lcs_pkg::*;

   lcs_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          slot_free;

   // Result register can take a new transaction
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (stat.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid && req_mode) state_in = ST_RD_SELF;
         end
         ST_RD_SELF:  state_in = ST_RD_BELOW;
         ST_RD_BELOW: state_in = ST_EMIT;
         ST_EMIT: begin
            if (slot_free) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // Outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: cmd.clear_wr = 1'b1;
         ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.load_wr   = req_valid && !req_mode;
            cmd.adv_start = req_valid && req_mode;
         end
         ST_RD_SELF:  cmd.rd_self  = 1'b1;
         ST_RD_BELOW: cmd.rd_below = 1'b1;
         ST_EMIT:     cmd.emit     = slot_free;
         default: ;
      endcase
   end

   // Result valid flag
   always_comb begin
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

### rtl/lcs_datapath.sv
// Grid store, scan position, neighbor count, B3/S23 rule and result register.
`default_nettype none

module lcs_datapath (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire lcs_pkg::lcs_cmd_type              cmd,
   output lcs_pkg::lcs_stat_type                  stat,
   input  wire logic                              req_cell_in,
   input  wire logic [lcs_pkg::FLD_ROW_W-1:0]     req_load_row,
   input  wire logic [lcs_pkg::FLD_COL_W-1:0]     req_load_col,
   input  wire logic                              csr_wr,
   input  wire logic [lcs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [lcs_pkg::CSR_DATA_W-1:0]    csr_data,
   output logic                                   rsp_cell_out,
   output logic      [lcs_pkg::FLD_ROW_W-1:0]     rsp_row_out,
   output logic      [lcs_pkg::FLD_COL_W-1:0]     rsp_col_out,
   output logic      [lcs_pkg::LIVE_W-1:0]        rsp_live_count,
   output logic                                   rsp_last
);
   import lcs_pkg::*;

   // Control registers
   logic [ROW_W-1:0]  scan_row_ff, scan_row_in;
   logic [COL_W-1:0]  scan_col_ff, scan_col_in;
   logic [LIVE_W-1:0] acc_ff, acc_in;
   logic              bank_ff, bank_in;
   logic [EXT_W-1:0]  rows_ff, rows_in;
   logic [EXT_W-1:0]  cols_ff, cols_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;

   // Payload registers
   logic [MAX_COLS-1:0] up_ff;
   logic [MAX_COLS-1:0] mid_ff;
   logic                cell_ff;
   logic [FLD_ROW_W-1:0] row_ff;
   logic [FLD_COL_W-1:0] col_ff;
   logic [LIVE_W-1:0]   live_ff;
   logic                last_ff;

   // RAM ports
   logic                ram_we;
   logic [ADDR_W-1:0]   ram_waddr;
   logic [MAX_COLS-1:0] ram_wmask;
   logic [MAX_COLS-1:0] ram_wdata;
   logic                ram_re;
   logic [ADDR_W-1:0]   ram_raddr;
   logic [MAX_COLS-1:0] ram_rdata;

   // Scan and window signals
   logic                  scan_oor;
   logic [ROW_W-1:0]      eff_row;
   logic [COL_W-1:0]      eff_col;
   logic                  up_valid;
   logic                  down_valid;
   logic [MAX_COLS-1:0]   col_mask;
   logic [MAX_COLS-1:0]   down_row;
   logic [MAX_COLS+1:0]   pad_up, pad_mid, pad_down;
   logic [PAD_IDX_W-1:0]  pad_idx;
   logic [2:0]            win_up, win_mid, win_down;
   logic [3:0]            nbr_count;
   logic                  self_cell;
   logic                  next_cell;
   logic                  is_last;
   logic                  col_wrap;
   logic [LIVE_W-1:0]     acc_sum;
   logic                  load_in_range;
   logic [MAX_COLS-1:0]   load_onehot;
   logic [MAX_COLS-1:0]   scan_onehot;

   lcs_ram #(
      .WIDTH (MAX_COLS),
      .DEPTH (RAM_WORDS)
   ) u_grid_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wmask (ram_wmask),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // Scan position falls outside the in-use area: restart from the origin
   assign scan_oor = (EXT_W'(scan_row_ff) >= rows_ff) || (EXT_W'(scan_col_ff) >= cols_ff);
   assign eff_row  = scan_oor ? '0 : scan_row_ff;
   assign eff_col  = scan_oor ? '0 : scan_col_ff;

   // Row neighbors inside the in-use area
   assign up_valid   = (scan_row_ff != '0);
   assign down_valid = (EXT_W'(scan_row_ff) + EXT_W'(1)) < rows_ff;

   // Columns inside the in-use area
   always_comb begin
      for (int j = 0; j < MAX_COLS; j++) begin
         col_mask[j] = (32'(j) < 32'(cols_ff));
      end
   end

   // Read address: row above at start, then self, then below
   always_comb begin
      ram_re    = cmd.adv_start || cmd.rd_self || cmd.rd_below;
      ram_raddr = {bank_ff, scan_row_ff};
      if (cmd.adv_start) begin
         ram_raddr = {bank_ff, eff_row - ROW_W'(1)};
      end else if (cmd.rd_below) begin
         ram_raddr = {bank_ff, scan_row_ff + ROW_W'(1)};
      end
   end

   // 3x3 window around the scanned cell, dead outside the borders
   assign down_row = down_valid ? ram_rdata : '0;
   assign pad_up   = {1'b0, up_ff & col_mask, 1'b0};
   assign pad_mid  = {1'b0, mid_ff & col_mask, 1'b0};
   assign pad_down = {1'b0, down_row & col_mask, 1'b0};
   assign pad_idx  = PAD_IDX_W'(scan_col_ff);
   assign win_up   = pad_up[pad_idx +: 3];
   assign win_mid  = pad_mid[pad_idx +: 3];
   assign win_down = pad_down[pad_idx +: 3];

   assign nbr_count = 4'(win_up[0]) + 4'(win_up[1]) + 4'(win_up[2])
                    + 4'(win_mid[0]) + 4'(win_mid[2])
                    + 4'(win_down[0]) + 4'(win_down[1]) + 4'(win_down[2]);
   assign self_cell = win_mid[1];

   // B3/S23
   assign next_cell = self_cell ? ((nbr_count == SURVIVE_LOW) || (nbr_count == BIRTH_COUNT))
                                : (nbr_count == BIRTH_COUNT);

   assign col_wrap = (EXT_W'(scan_col_ff) + EXT_W'(1)) >= cols_ff;
   assign is_last  = ((EXT_W'(scan_row_ff) + EXT_W'(1)) == rows_ff)
                  && ((EXT_W'(scan_col_ff) + EXT_W'(1)) == cols_ff);
   assign acc_sum  = acc_ff + LIVE_W'(next_cell);

   // Single-bit write lanes
   assign load_in_range = (32'(req_load_row) < MAX_ROWS) && (32'(req_load_col) < MAX_COLS);
   assign load_onehot   = MAX_COLS'(1) << COL_W'(req_load_col);
   assign scan_onehot   = MAX_COLS'(1) << scan_col_ff;

   // Write port: clearing pass, cell load, or next-generation cell
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = clr_addr_ff;
      ram_wmask = '1;
      ram_wdata = '0;
      if (cmd.clear_wr) begin
         ram_we = 1'b1;
      end else if (cmd.load_wr) begin
         ram_we    = load_in_range;
         ram_waddr = {bank_ff, ROW_W'(req_load_row)};
         ram_wmask = load_onehot;
         ram_wdata = {MAX_COLS{req_cell_in}};
      end else if (cmd.emit) begin
         ram_we    = 1'b1;
         ram_waddr = {!bank_ff, scan_row_ff};
         ram_wmask = scan_onehot;
         ram_wdata = {MAX_COLS{next_cell}};
      end
   end

   assign stat.clear_last = (clr_addr_ff == '1);

   // Next values of control registers
   always_comb begin
      scan_row_in = scan_row_ff;
      scan_col_in = scan_col_ff;
      acc_in      = acc_ff;
      bank_in     = bank_ff;
      rows_in     = rows_ff;
      cols_in     = cols_ff;
      clr_addr_in = clr_addr_ff;

      if (cmd.clear_wr) begin
         clr_addr_in = clr_addr_ff + ADDR_W'(1);
      end

      if (csr_wr) begin
         case (csr_index)
            CSR_ROWS_IN_USE: rows_in = clamp_extent(csr_data, MAX_ROWS);
            CSR_COLS_IN_USE: cols_in = clamp_extent(csr_data, MAX_COLS);
            default: ;
         endcase
         if ((csr_index == CSR_ROWS_IN_USE) || (csr_index == CSR_COLS_IN_USE)) begin
            scan_row_in = '0;
            scan_col_in = '0;
            acc_in      = '0;
         end
      end else if (cmd.load_wr) begin
         scan_row_in = '0;
         scan_col_in = '0;
         acc_in      = '0;
      end else if (cmd.adv_start) begin
         scan_row_in = eff_row;
         scan_col_in = eff_col;
         acc_in      = scan_oor ? '0 : acc_ff;
      end else if (cmd.emit) begin
         if (is_last) begin
            bank_in     = !bank_ff;
            scan_row_in = '0;
            scan_col_in = '0;
            acc_in      = '0;
         end else if (col_wrap) begin
            scan_row_in = scan_row_ff + ROW_W'(1);
            scan_col_in = '0;
            acc_in      = acc_sum;
         end else begin
            scan_col_in = scan_col_ff + COL_W'(1);
            acc_in      = acc_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_row_ff <= '0;
         scan_col_ff <= '0;
         acc_ff      <= '0;
         bank_ff     <= 1'b0;
         rows_ff     <= clamp_extent(EXTENT_RESET, MAX_ROWS);
         cols_ff     <= clamp_extent(EXTENT_RESET, MAX_COLS);
         clr_addr_ff <= '0;
      end else begin
         scan_row_ff <= scan_row_in;
         scan_col_ff <= scan_col_in;
         acc_ff      <= acc_in;
         bank_ff     <= bank_in;
         rows_ff     <= rows_in;
         cols_ff     <= cols_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // Captured rows and result payload
   always_ff @(posedge clock) begin
      if (cmd.rd_self) begin
         up_ff <= up_valid ? ram_rdata : '0;
      end
      if (cmd.rd_below) begin
         mid_ff <= ram_rdata;
      end
      if (cmd.emit) begin
         cell_ff <= next_cell;
         row_ff  <= FLD_ROW_W'(scan_row_ff);
         col_ff  <= FLD_COL_W'(scan_col_ff);
         live_ff <= acc_sum;
         last_ff <= is_last;
      end
   end

   assign rsp_cell_out   = cell_ff;
   assign rsp_row_out    = row_ff;
   assign rsp_col_out    = col_ff;
   assign rsp_live_count = live_ff;
   assign rsp_last       = last_ff;

endmodule

`default_nettype wire

### rtl/life_automaton_step.sv
// Top level of the life automaton step block.
//
//   channel | dir | handshake            | payload
//   --------+-----+----------------------+-------------------------------------------
//   req_if  | in  | valid / ready        | mode, cell_in, load_row, load_col
//   rsp_if  | out | valid / ready        | cell_out, row_out, col_out, live_count, last
//   csr_if  | in  | valid / ready (=1)   | index, data
//
// A load writes its cell as it is accepted; an advance reads the row above as it is
// accepted, then the row itself and the row below through the single RAM read port,
// and then computes and writes back the new cell. After reset a clearing pass zeroes
// all RAM_WORDS words (128 at the default size) of both banks; req_if.ready stays low
// meanwhile. A result waiting on rsp_if does not block accepting the next transaction;
// an advance then holds in its write-back state until the result register frees up.
`default_nettype none

module life_automaton_step (
   input wire logic clock,
   input wire logic reset,
   lcs_req_if.sink  req_if,
   lcs_rsp_if.source rsp_if,
   lcs_csr_if.sink  csr_if
);
   import lcs_pkg::*;

   lcs_cmd_type  cmd;
   lcs_stat_type stat;
   logic         csr_wr;

   // Register writes are always taken
   assign csr_if.ready = 1'b1;
   assign csr_wr       = csr_if.valid;

   lcs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_mode  (req_if.mode),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   lcs_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_cell_in    (req_if.cell_in),
      .req_load_row   (req_if.load_row),
      .req_load_col   (req_if.load_col),
      .csr_wr         (csr_wr),
      .csr_index      (csr_if.index),
      .csr_data       (csr_if.data),
      .rsp_cell_out   (rsp_if.cell_out),
      .rsp_row_out    (rsp_if.row_out),
      .rsp_col_out    (rsp_if.col_out),
      .rsp_live_count (rsp_if.live_count),
      .rsp_last       (rsp_if.last)
   );

endmodule

`default_nettype wire

### rtl/lcs_checker.sv
// Port-level checks for the life automaton step block, bound to the top level.
`default_nettype none

module lcs_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_ready,
   input wire logic                          req_mode,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic                          rsp_cell_out,
   input wire logic [lcs_pkg::FLD_ROW_W-1:0] rsp_row_out,
   input wire logic [lcs_pkg::FLD_COL_W-1:0] rsp_col_out,
   input wire logic [lcs_pkg::LIVE_W-1:0]    rsp_live_count,
   input wire logic                          rsp_last
);

   // Held result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cell_out) && $stable(rsp_row_out)
         && $stable(rsp_col_out) && $stable(rsp_live_count) && $stable(rsp_last))
      else $error("response payload changed while stalled");

   // Clearing pass blocks requests right after reset
   a_clear_busy: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request accepted during clearing pass");

   // A load never yields a result
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_mode |=> !$rose(rsp_valid))
      else $error("load transaction produced a response");

   // A live cell is counted in its own running total
   a_live_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_cell_out |-> rsp_live_count != '0)
      else $error("live cell emitted with zero live count");

   // An advance keeps the block busy on the next cycle
   a_adv_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_mode |=> !req_ready)
      else $error("request ready right after an advance");

endmodule

bind life_automaton_step lcs_checker u_lcs_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_if.valid),
   .req_ready      (req_if.ready),
   .req_mode       (req_if.mode),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .rsp_cell_out   (rsp_if.cell_out),
   .rsp_row_out    (rsp_if.row_out),
   .rsp_col_out    (rsp_if.col_out),
   .rsp_live_count (rsp_if.live_count),
   .rsp_last       (rsp_if.last)
);

`default_nettype wire
